/* hdl/mbps_pkg.sv */
// Shared types and constants for the masked byte pattern search block.
// No dependencies; used by the interfaces, the comparator and the top level.
`default_nettype none
package mbps_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned REG_W    = 64;
	localparam int unsigned MASK_W   = 24;
	localparam int unsigned LEN_W    = 5;
	localparam int unsigned OFS_W    = 8;
	localparam int unsigned PAT_W    = 3 * REG_W;
	localparam int unsigned INDEX_W  = 3;

	// register indexes of the configuration port
	typedef enum logic [INDEX_W-1:0] {
		CFG_PAT_LOW  = 3'd0,
		CFG_PAT_MID  = 3'd1,
		CFG_PAT_HIGH = 3'd2,
		CFG_CARE     = 3'd3,
		CFG_LENGTH   = 3'd4,
		CFG_BASE     = 3'd5,
		CFG_OFFSET   = 3'd6
	} cfg_idx_e;

	typedef struct packed {
		logic [PAT_W-1:0]  pattern;   // byte k in bits 8k+7..8k
		logic [MASK_W-1:0] care;
		logic [LEN_W-1:0]  length;
		logic [ADDR_W-1:0] base;
		logic [OFS_W-1:0]  offset;
	} cfg_t;

endpackage
`default_nettype wire

/* hdl/mbps_if.sv */
// Stream interfaces: scanned bytes in, search results out.
// Depends on mbps_pkg for field widths.
`default_nettype none
interface mbps_byte_if;
	logic                        valid;
	logic                        ready;
	logic [mbps_pkg::DATA_W-1:0] data_byte;
	logic                        is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface mbps_result_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [mbps_pkg::ADDR_W-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink   (input valid, input found, input match_address, output ready);
endinterface
`default_nettype wire

/* hdl/mbps_match.sv */
// Parallel masked comparison of the byte window against the pattern.
// Depends on mbps_pkg (cfg_t, widths). Purely combinational.
`default_nettype none
module mbps_match #(
	parameter int unsigned MAX_PATTERN = 24
) (
	input  wire logic [7:0]                 win [MAX_PATTERN],
	input  wire mbps_pkg::cfg_t             cfg,
	input  wire logic [mbps_pkg::LEN_W-1:0] len,
	output logic                            hit
);
	localparam int unsigned IDX_W = $clog2(MAX_PATTERN);

	logic [MAX_PATTERN-1:0] miss;

	// pattern byte k lines up with window entry len-1-k (entry 0 newest)
	always_comb begin
		logic [mbps_pkg::LEN_W-1:0] idx;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			idx = len - 1'b1 - mbps_pkg::LEN_W'(k);
			miss[k] = (mbps_pkg::LEN_W'(k) < len) && cfg.care[k] &&
				(win[idx[IDX_W-1:0]] != cfg.pattern[8*k +: 8]);
		end
		hit = ~|miss;
	end
endmodule
`default_nettype wire

/* hdl/masked_byte_pattern_search.sv */
// Masked byte pattern search, top level.
// Depends on mbps_pkg, mbps_byte_if / mbps_result_if and mbps_match.
//
// Usage:
//  - scan (sink): one region byte per beat, is_last on the final byte.
//  - result (source): one beat per region; found=1 with the match address
//    (base + position of the window's first byte + offset, mod 2^32) at the
//    first full-window match if base != 0, or found=0 / address 0 when
//    the region ends without one. Bytes after a match are consumed silently.
//  - wr_en / wr_index / wr_data: register writes, only while idle. Indexes
//    above the list are dropped.
// Timing: an accepted byte lands in the s1 register; the comparison of the
// shifted window and the address add run combinationally from s1 and write
// the result register when the s1 byte advances.
// Throughput is one byte per cycle, set by the single window/compare stage,
// while no stall holds a byte in s1.
// Stall: the result register holds a result until taken; bytes that make no
// result keep flowing, and a byte that would make a result waits in s1,
// which then drops scan.ready.
// Reset: arst_n clears the scan counters and the s1 and result valid flags;
// config: pattern 0, care mask all ones, length 1, base 0, offset 0.
`default_nettype none
module masked_byte_pattern_search #(
	parameter int unsigned MAX_PATTERN = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	mbps_byte_if.sink                           scan,
	mbps_result_if.source                       result,
	input  wire logic                           wr_en,
	input  wire logic [mbps_pkg::INDEX_W-1:0]   wr_index,
	input  wire logic [mbps_pkg::REG_W-1:0]     wr_data
);
	localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned LEN_W  = mbps_pkg::LEN_W;
	localparam int unsigned ADDR_W = mbps_pkg::ADDR_W;

	// ---------------- configuration registers ----------------
	mbps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.care    <= '1;
			cfg_q.length  <= LEN_W'(1);
			cfg_q.base    <= '0;
			cfg_q.offset  <= '0;
		end else if (wr_en) begin
			case (mbps_pkg::cfg_idx_e'(wr_index))
				mbps_pkg::CFG_PAT_LOW:  cfg_q.pattern[63:0]    <= wr_data;
				mbps_pkg::CFG_PAT_MID:  cfg_q.pattern[127:64]  <= wr_data;
				mbps_pkg::CFG_PAT_HIGH: cfg_q.pattern[191:128] <= wr_data;
				mbps_pkg::CFG_CARE:     cfg_q.care   <= wr_data[mbps_pkg::MASK_W-1:0];
				mbps_pkg::CFG_LENGTH:   cfg_q.length <= wr_data[LEN_W-1:0];
				mbps_pkg::CFG_BASE:     cfg_q.base   <= wr_data[ADDR_W-1:0];
				mbps_pkg::CFG_OFFSET:   cfg_q.offset <= wr_data[mbps_pkg::OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// length in use: 0 acts as 1, anything above the window acts as full
	logic [LEN_W-1:0] len_used;
	always_comb begin
		if (cfg_q.length == '0)
			len_used = LEN_W'(1);
		else if (cfg_q.length > LEN_W'(MAX_PATTERN))
			len_used = LEN_W'(MAX_PATTERN);
		else
			len_used = cfg_q.length;
	end

	// ---------------- input stage ----------------
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       adv_s1;     // s1 byte is consumed this cycle

	assign scan.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (scan.valid && scan.ready)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			data_s1 <= scan.data_byte;
			last_s1 <= scan.is_last;
		end
	end

	// ---------------- scan state ----------------
	// Window entries are not cleared: the fill count keeps unwritten ones out.
	logic [7:0]        win_q [MAX_PATTERN];
	logic [7:0]        win_next [MAX_PATTERN];
	logic [FILL_W-1:0] fill_q, fill_next;
	logic [ADDR_W-1:0] pos_q, pos_next;
	logic              done_q;

	always_comb begin
		win_next[0] = data_s1;
		for (int i = 1; i < MAX_PATTERN; i++)
			win_next[i] = win_q[i-1];
		fill_next = (fill_q == FILL_W'(MAX_PATTERN)) ? fill_q : fill_q + 1'b1;
		pos_next  = pos_q + 1'b1;
	end

	logic pat_hit;

	mbps_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.win (win_next),
		.cfg (cfg_q),
		.len (len_used),
		.hit (pat_hit)
	);

	logic              hit;
	logic              emit;
	logic [ADDR_W-1:0] addr;

	assign hit  = !done_q && (cfg_q.base != '0) &&
		((LEN_W + 1)'(fill_next) >= (LEN_W + 1)'(len_used)) && pat_hit;
	assign emit = hit || (last_s1 && !done_q);
	assign addr = cfg_q.base + (pos_next - ADDR_W'(len_used)) + ADDR_W'(cfg_q.offset);

	assign adv_s1 = valid_s1 && (!emit || !result.valid || result.ready);

	always_ff @(posedge clk) begin
		if (adv_s1)
			win_q <= win_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			done_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				// region over: next byte starts a fresh scan
				fill_q <= '0;
				pos_q  <= '0;
				done_q <= 1'b0;
			end else begin
				fill_q <= fill_next;
				pos_q  <= pos_next;
				done_q <= done_q || hit;
			end
		end
	end

	// ---------------- result register ----------------
	logic              res_valid_q;
	logic              res_found_q;
	logic [ADDR_W-1:0] res_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv_s1 && emit)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			res_found_q <= hit;
			res_addr_q  <= hit ? addr : '0;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.found         = res_found_q;
	assign result.match_address = res_addr_q;

	// ---------------- assertions ----------------
	// a result is never overwritten while it waits
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(res_addr_q) && $stable(res_found_q))
		else $error("pending result overwritten");

	// a not-found result always carries a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |-> result.match_address == '0)
		else $error("not-found result with nonzero address");

	// a match mid-region blocks any further result in that region
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && hit && !last_s1 |=> done_q)
		else $error("match not recorded");

	// scan stalls only behind a held s1 byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!scan.ready |-> valid_s1 && emit && result.valid)
		else $error("scan stalled without cause");

endmodule
`default_nettype wire
